>>> src/brpwm_pkg.sv
// Shared constants, types and helpers for the breathing PWM generator.
// No dependencies; every module of the block imports this package.
package brpwm_pkg;

    localparam int CNT_W      = 16;
    localparam int DEPTH      = 13;
    localparam int POS_W      = 4;
    localparam int RECIP_SH   = 23;
    localparam int RECIP_W    = 23;
    localparam int PROD_W     = CNT_W + RECIP_W;

    // register index codes (byte address bit 2)
    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_STEP   = 1'b1;

    localparam logic [CNT_W-1:0] PERIOD_RST = 16'd1843;
    localparam logic [CNT_W-1:0] STEP_RST   = 16'd46068;

    // duty percentage r scaled to ceil(r * 2^23 / 100); with a 16-bit period the
    // scaled product shifted down by 23 equals floor(period * r / 100) exactly
    localparam logic [RECIP_W-1:0] DUTY_RECIP [DEPTH] = '{
        23'((5  * (2**RECIP_SH) + 99) / 100),
        23'((18 * (2**RECIP_SH) + 99) / 100),
        23'((30 * (2**RECIP_SH) + 99) / 100),
        23'((41 * (2**RECIP_SH) + 99) / 100),
        23'((51 * (2**RECIP_SH) + 99) / 100),
        23'((60 * (2**RECIP_SH) + 99) / 100),
        23'((68 * (2**RECIP_SH) + 99) / 100),
        23'((75 * (2**RECIP_SH) + 99) / 100),
        23'((81 * (2**RECIP_SH) + 99) / 100),
        23'((86 * (2**RECIP_SH) + 99) / 100),
        23'((90 * (2**RECIP_SH) + 99) / 100),
        23'((93 * (2**RECIP_SH) + 99) / 100),
        23'((95 * (2**RECIP_SH) + 99) / 100)
    };

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             up;
        logic [CNT_W-1:0] low_len;
        logic [CNT_W-1:0] high_len;
    } duty_step_t;

    // a zero-length phase still lasts one tick
    function automatic logic [CNT_W-1:0] phase_load(input logic [CNT_W-1:0] len);
        phase_load = (len == '0) ? CNT_W'(1) : len;
    endfunction

endpackage

>>> src/breathing_pwm_generator_core.sv
// Top level of the breathing PWM generator: register port, input register
// and the counter engine. Depends on brpwm_pkg and brpwm_engine.
//
// channel   | direction | transfer on                  | payload
// s_axis    | in        | s_tvalid && s_tready         | tick
// m_axis    | out       | m_tvalid && m_tready         | pwm_level, duty_index, step_event
// apb       | in        | psel && penable && pwrite    | period_ticks, step_ticks
//
// One item per cycle while the result is not stalled; each item passes through the input
// register and is folded into the counters as it moves into the result register.
// A stalled result holds the engine; the input register still takes one more item.
// Reset clears the counters and loads the register defaults.
module breathing_pwm_generator_core
    import brpwm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] tick, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] pwm_level, [4:1] duty_index, [5] step_event, [7:6] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] period_reg;
    logic [CNT_W-1:0] step_reg;
    logic             iv_reg;
    logic             itick_reg;
    logic             eng_ready;
    logic             wr_en;
    logic             o_level;
    logic [POS_W-1:0] o_pos;
    logic             o_step;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            step_reg   <= STEP_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_PERIOD: period_reg <= pwdata[CNT_W-1:0];
                REG_STEP:   step_reg   <= pwdata[CNT_W-1:0];
                default:    period_reg <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PERIOD: prdata = 32'(period_reg);
            REG_STEP:   prdata = 32'(step_reg);
            default:    prdata = '0;
        endcase
    end

    // input register: refill whenever the engine drains it
    assign s_tready = !iv_reg || eng_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            iv_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            itick_reg <= s_tdata[0];
        end
    end

    brpwm_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .period    (period_reg),
        .step_len  (step_reg),
        .in_valid  (iv_reg),
        .in_tick   (itick_reg),
        .in_ready  (eng_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_level (o_level),
        .out_pos   (o_pos),
        .out_step  (o_step)
    );

    assign m_tdata = {2'b00, o_step, o_pos, o_level};

endmodule

>>> src/brpwm_duty.sv
// Next duty position and phase lengths for one table step.
// Depends on brpwm_pkg (table, widths, duty_step_t).
module brpwm_duty
    import brpwm_pkg::*;
(
    input  logic [POS_W-1:0] pos,
    input  logic             up,
    input  logic [CNT_W-1:0] period,
    output duty_step_t       step
);

    logic [POS_W-1:0]  pos_move;
    logic [POS_W-1:0]  pos_new;
    logic              up_new;
    logic [POS_W-1:0]  idx;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  lo;

    always_comb
    begin
        if (up)
        begin
            pos_move = pos + POS_W'(1);
        end
        else if (pos != '0)
        begin
            pos_move = pos - POS_W'(1);
        end
        else
        begin
            pos_move = '0;
        end

        pos_new = pos_move;
        up_new  = up;
        // bounce at both ends of the triangle
        if ((pos_move <= POS_W'(1)) && !up)
        begin
            pos_new = POS_W'(1);
            up_new  = 1'b1;
        end
        else if ((pos_move >= POS_W'(DEPTH)) && up)
        begin
            pos_new = POS_W'(DEPTH);
            up_new  = 1'b0;
        end

        idx = (pos_new == '0) ? '0 : pos_new - POS_W'(1);
        if (idx > POS_W'(DEPTH - 1))
        begin
            idx = POS_W'(DEPTH - 1);
        end
    end

    assign prod = PROD_W'(period) * PROD_W'(DUTY_RECIP[idx]);
    assign lo   = prod[RECIP_SH +: CNT_W];

    assign step.pos      = pos_new;
    assign step.up       = up_new;
    assign step.low_len  = lo;
    assign step.high_len = period - lo;

endmodule

>>> src/brpwm_engine.sv
// Counter state, per-tick update and result register of the PWM generator.
// Depends on brpwm_pkg and brpwm_duty.
module brpwm_engine
    import brpwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] period,
    input  logic [CNT_W-1:0] step_len,
    input  logic             in_valid,
    input  logic             in_tick,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_level,
    output logic [POS_W-1:0] out_pos,
    output logic             out_step
);

    logic             lvl_reg,   lvl_next;
    logic [CNT_W-1:0] pc_reg,    pc_next;
    logic [CNT_W-1:0] sc_reg,    sc_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic             up_reg,    up_next;
    logic             run_reg,   run_next;
    logic [CNT_W-1:0] low_reg,   low_next;
    logic [CNT_W-1:0] high_reg,  high_next;
    logic             ov_reg;
    logic             olvl_reg;
    logic [POS_W-1:0] opos_reg;
    logic             ostep_reg;
    logic             stepped;
    logic             advance;
    logic [CNT_W-1:0] pc_dec;
    logic [CNT_W-1:0] sc_inc;
    duty_step_t       duty;

    brpwm_duty u_duty (
        .pos    (pos_reg),
        .up     (up_reg),
        .period (period),
        .step   (duty)
    );

    assign in_ready = !ov_reg || out_ready;
    assign advance  = in_valid && in_ready;
    assign pc_dec   = pc_reg - CNT_W'(1);
    assign sc_inc   = sc_reg + CNT_W'(1);

    always_comb
    begin
        lvl_next  = lvl_reg;
        pc_next   = pc_reg;
        sc_next   = sc_reg;
        pos_next  = pos_reg;
        up_next   = up_reg;
        run_next  = run_reg;
        low_next  = low_reg;
        high_next = high_reg;
        stepped   = 1'b0;
        if (in_tick)
        begin
            if (run_reg)
            begin
                if (pc_dec == '0)
                begin
                    lvl_next = !lvl_reg;
                    pc_next  = phase_load(!lvl_reg ? high_reg : low_reg);
                end
                else
                begin
                    pc_next = pc_dec;
                end
            end
            // a zero step length acts as one: the wrapped count also fires
            if ((sc_inc >= step_len) || (sc_inc == '0))
            begin
                sc_next   = '0;
                pos_next  = duty.pos;
                up_next   = duty.up;
                low_next  = duty.low_len;
                high_next = duty.high_len;
                pc_next   = phase_load(duty.high_len);
                run_next  = 1'b1;
                stepped   = 1'b1;
            end
            else
            begin
                sc_next = sc_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg  <= 1'b0;
            pc_reg   <= '0;
            sc_reg   <= '0;
            pos_reg  <= '0;
            up_reg   <= 1'b1;
            run_reg  <= 1'b0;
            low_reg  <= '0;
            high_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                lvl_reg  <= lvl_next;
                pc_reg   <= pc_next;
                sc_reg   <= sc_next;
                pos_reg  <= pos_next;
                up_reg   <= up_next;
                run_reg  <= run_next;
                low_reg  <= low_next;
                high_reg <= high_next;
                ov_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            olvl_reg  <= lvl_next;
            opos_reg  <= pos_next;
            ostep_reg <= stepped;
        end
    end

    assign out_valid = ov_reg;
    assign out_level = olvl_reg;
    assign out_pos   = opos_reg;
    assign out_step  = ostep_reg;

    a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(run_reg))
        else $error("phase counter stopped after running");

    a_low_before_run: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> (!lvl_reg && (pos_reg == '0)))
        else $error("level or position moved before the first step");

    a_step_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && ostep_reg) |-> ((opos_reg != '0) && (opos_reg <= POS_W'(DEPTH))))
        else $error("step result with position off the table");

    a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && stepped) |=> ((sc_reg == '0) && run_reg && (pc_reg != '0)))
        else $error("step did not restart the counters");

endmodule
